[rtl/des_pkg.sv]
// shared types and constants for the delayed event scheduler
`default_nettype none
package des_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int FIRE_W      = $clog2(MAX_RESULTS);
	localparam int FIRE_CW     = FIRE_W + 1;
	localparam int PROD_W      = 42;

	localparam logic [9:0] US_PER_MS       = 10'd1000;
	localparam logic [3:0] RESUME_GUARD_US = 4'd10;

	localparam logic [2:0] KIND_SCHEDULE = 3'd0;
	localparam logic [2:0] KIND_CANCEL   = 3'd1;
	localparam logic [2:0] KIND_TICK     = 3'd2;
	localparam logic [2:0] KIND_SUSPEND  = 3'd3;
	localparam logic [2:0] KIND_RESUME   = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_SUSPENDED = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] task_id;
		logic [31:0] wait_ms;
		logic        repeating;
		logic [63:0] now_us;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        fired_valid;
		logic [31:0] fired_id;
		logic        alarm_valid;
		logic [31:0] alarm_time;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] target;
		logic [31:0] interval;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage
`default_nettype wire

[rtl/des_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module des_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

[rtl/delayed_event_scheduler.sv]
// delayed event scheduler: slot table walked by a small sequencer
//
// Requests arrive on req (valid/ready) and results leave on rsp (valid/ready).
// Each request is one of schedule, cancel, tick, suspend or resume. Every
// request gives one result, except a tick that fires events: it gives one
// result per fired event in slot order, at most 16, with last set on the
// final one. Every result carries the low 32 bits of the earliest pending
// target after the request.
// One request walks the slot ram slot by slot before its first result (and
// then S_SCH for schedule): each slot passes a read state S_EV and an
// update/write-back state S_WB through the shared multiply/add/compare path.
// Further tick results follow one per cycle unless rsp stalls. req_ready is
// high only while the sequencer is idle; a finished result sits in the output
// register, and a stalled receiver holds the sequencer in its result phase.
// Reset clears all slot valid bits and the suspended flag; slot ram contents
// are left as they are, since the contents of a free slot are never used.
`default_nettype none
module delayed_event_scheduler #(
	parameter int SLOTS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire des_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output des_pkg::rsp_t      rsp
);
	import des_pkg::*;

	localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_EV    = 6'b000100,
		S_WB    = 6'b001000,
		S_SCH   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	req_t        op_q;
	logic        susp_q;
	logic [63:0] susp_start_q;
	logic        tick_act_q;
	logic        tick_susp_q;
	logic        resume_act_q;
	logic [63:0] elapsed_q;
	logic [63:0] floor_q;
	logic [PROD_W-1:0] sched_prod_q;
	logic [PROD_W-1:0] prod_q;
	logic        due_q;
	logic        match_q;
	logic [63:0] moved_q;
	logic [SLOTS-1:0] valid_q;
	logic [IW-1:0] idx_q;
	logic        dup_q;
	logic        have_free_q;
	logic [IW-1:0] free_q;
	logic        found_q;
	logic        min_valid_q;
	logic [63:0] min_q;
	logic [31:0] fid_q [MAX_RESULTS];
	logic [FIRE_CW-1:0] nfire_q;
	logic [FIRE_CW-1:0] emit_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// ram
	logic            ram_wr_en;
	logic [IW-1:0]   ram_wr_addr;
	slot_t           ram_wr_data;
	logic            ram_rd_en;
	logic [IW-1:0]   ram_rd_addr;
	logic [SLOT_W-1:0] ram_rd_raw;
	slot_t           cur;

	des_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_raw)
	);

	assign cur = slot_t'(ram_rd_raw);

	// shared multiplier: delay at start, slot interval per slot
	logic [31:0]       mul_a;
	logic [PROD_W-1:0] mul_p;
	assign mul_a = (state_q == S_START) ? op_q.wait_ms : cur.interval;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(US_PER_MS);

	logic is_last;
	assign is_last = (idx_q == LAST_IDX);

	// per-slot update in the write-back cycle
	logic        cur_v;
	logic        wb_valid;
	logic [63:0] wb_target;
	logic        wb_write;
	logic        wb_push;
	logic [63:0] sch_target;

	always_comb begin
		cur_v     = valid_q[idx_q];
		wb_valid  = cur_v;
		wb_target = cur.target;
		wb_write  = 1'b0;
		wb_push   = 1'b0;
		case (op_q.kind)
			KIND_CANCEL: begin
				if (cur_v && match_q) begin
					wb_valid = 1'b0;
				end
			end
			KIND_TICK: begin
				if (tick_act_q && cur_v && due_q && nfire_q < FIRE_CW'(MAX_RESULTS)) begin
					wb_push = 1'b1;
					if (cur.interval != 32'd0) begin
						wb_target = cur.target + 64'(prod_q);
						wb_write  = 1'b1;
					end else begin
						wb_valid = 1'b0;
					end
				end
			end
			KIND_RESUME: begin
				if (resume_act_q && cur_v) begin
					wb_target = (moved_q > floor_q) ? moved_q : floor_q;
					wb_write  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sch_target = op_q.now_us + 64'(sched_prod_q);

	logic sch_ok;
	assign sch_ok = !dup_q && have_free_q;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = cur;
		ram_wr_data.target = wb_target;
		if (state_q == S_WB) begin
			ram_wr_en = wb_write;
		end else if (state_q == S_SCH) begin
			ram_wr_en            = sch_ok;
			ram_wr_addr          = free_q;
			ram_wr_data.id       = op_q.task_id;
			ram_wr_data.target   = sch_target;
			ram_wr_data.interval = op_q.repeating ? op_q.wait_ms : 32'd0;
		end
	end

	assign ram_rd_en   = (state_q == S_START) || (state_q == S_WB && !is_last);
	assign ram_rd_addr = (state_q == S_START) ? '0 : idx_q + IW'(1);

	// result assembly
	logic               fired_any;
	logic [FIRE_CW-1:0] nres;
	logic               emit_last;
	logic               emit_load;
	logic [2:0]         res_status;

	assign fired_any = tick_act_q && (nfire_q != '0);
	assign nres      = fired_any ? nfire_q : FIRE_CW'(1);
	assign emit_last = (emit_q + FIRE_CW'(1)) == nres;
	assign emit_load = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		res_status = ST_OK;
		case (op_q.kind)
			KIND_SCHEDULE: begin
				if (dup_q) begin
					res_status = ST_DUPLICATE;
				end else if (!have_free_q) begin
					res_status = ST_FULL;
				end
			end
			KIND_CANCEL: res_status = found_q ? ST_OK : ST_NOT_FOUND;
			KIND_TICK:   res_status = tick_susp_q ? ST_SUSPENDED : ST_OK;
			default:     res_status = ST_OK;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			susp_q       <= 1'b0;
			susp_start_q <= '0;
			valid_q      <= '0;
			rsp_valid_q  <= 1'b0;
			idx_q        <= '0;
			nfire_q      <= '0;
			emit_q       <= '0;
			tick_act_q   <= 1'b0;
			tick_susp_q  <= 1'b0;
			resume_act_q <= 1'b0;
			dup_q        <= 1'b0;
			have_free_q  <= 1'b0;
			found_q      <= 1'b0;
			min_valid_q  <= 1'b0;
		end else begin
			if (emit_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					tick_act_q   <= (op_q.kind == KIND_TICK) && !susp_q;
					tick_susp_q  <= (op_q.kind == KIND_TICK) && susp_q;
					resume_act_q <= (op_q.kind == KIND_RESUME) && susp_q;
					if (op_q.kind == KIND_SUSPEND && !susp_q) begin
						susp_q       <= 1'b1;
						susp_start_q <= op_q.now_us;
					end
					if (op_q.kind == KIND_RESUME) begin
						susp_q <= 1'b0;
					end
					idx_q       <= '0;
					nfire_q     <= '0;
					emit_q      <= '0;
					dup_q       <= 1'b0;
					have_free_q <= 1'b0;
					found_q     <= 1'b0;
					min_valid_q <= 1'b0;
					state_q     <= S_EV;
				end
				S_EV: begin
					state_q <= S_WB;
				end
				S_WB: begin
					valid_q[idx_q] <= wb_valid;
					if (op_q.kind == KIND_SCHEDULE) begin
						if (cur_v && match_q) begin
							dup_q <= 1'b1;
						end
						if (!cur_v && !have_free_q) begin
							have_free_q <= 1'b1;
						end
					end
					if (op_q.kind == KIND_CANCEL && cur_v && match_q) begin
						found_q <= 1'b1;
					end
					if (wb_push) begin
						nfire_q <= nfire_q + FIRE_CW'(1);
					end
					if (wb_valid && (!min_valid_q || wb_target < min_q)) begin
						min_valid_q <= 1'b1;
					end
					if (is_last) begin
						state_q <= (op_q.kind == KIND_SCHEDULE) ? S_SCH : S_EMIT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_EV;
					end
				end
				S_SCH: begin
					if (sch_ok) begin
						valid_q[free_q] <= 1'b1;
						min_valid_q     <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						emit_q <= emit_q + FIRE_CW'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q <= req;
		end
		if (state_q == S_START) begin
			sched_prod_q <= mul_p;
			elapsed_q    <= op_q.now_us - susp_start_q;
			floor_q      <= op_q.now_us + 64'(RESUME_GUARD_US);
		end
		if (state_q == S_EV) begin
			prod_q  <= mul_p;
			due_q   <= cur.target <= op_q.now_us;
			match_q <= cur.id == op_q.task_id;
			moved_q <= cur.target + elapsed_q;
		end
		if (state_q == S_WB) begin
			if (op_q.kind == KIND_SCHEDULE && !cur_v && !have_free_q) begin
				free_q <= idx_q;
			end
			if (wb_push) begin
				fid_q[nfire_q[FIRE_W-1:0]] <= cur.id;
			end
			if (wb_valid && (!min_valid_q || wb_target < min_q)) begin
				min_q <= wb_target;
			end
		end
		if (state_q == S_SCH && sch_ok && (!min_valid_q || sch_target < min_q)) begin
			min_q <= sch_target;
		end
		if (emit_load) begin
			rsp_q.status      <= res_status;
			rsp_q.fired_valid <= fired_any;
			rsp_q.fired_id    <= fired_any ? fid_q[emit_q[FIRE_W-1:0]] : 32'd0;
			rsp_q.alarm_valid <= min_valid_q;
			rsp_q.alarm_time  <= min_valid_q ? min_q[31:0] : 32'd0;
			rsp_q.last        <= emit_last;
		end
	end
endmodule
`default_nettype wire

[dv/des_event_checker.sv]
// checker for the delayed event scheduler: watches both channels, predicts results, compares
`timescale 1ns / 1ps
module des_event_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_ready,
	input  wire des_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_ready,
	input  wire des_pkg::rsp_t rsp,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen,
	output int                 fires_seen
);
	import des_pkg::*;

	localparam int SLOTS = 16;

	// shadow copy of the slot table
	logic        slot_live   [SLOTS];
	logic [31:0] slot_tag    [SLOTS];
	logic [63:0] slot_due    [SLOTS];
	logic [31:0] slot_period [SLOTS];
	logic        paused;
	logic [63:0] pause_start;

	rsp_t scheduler_results [$];
	rsp_t want;

	function automatic rsp_t make_result(input logic [2:0] st, input logic fv,
			input logic [31:0] fid);
		rsp_t one;
		one = '0;
		one.status      = st;
		one.fired_valid = fv;
		one.fired_id    = fid;
		return one;
	endfunction

	task automatic predict_scheduler(input req_t r);
		rsp_t        batch [$];
		logic [2:0]  st;
		int          free_idx;
		int          i;
		logic        found;
		logic        any;
		logic [63:0] best;
		logic [63:0] elapsed;
		logic [63:0] floor_us;
		logic [63:0] moved;
		rsp_t        one;
		case (r.kind)
			KIND_SCHEDULE: begin
				st = ST_OK;
				free_idx = -1;
				for (i = 0; i < SLOTS; i++) begin
					if (slot_live[i] && slot_tag[i] == r.task_id)
						st = ST_DUPLICATE;
					if (!slot_live[i] && free_idx < 0)
						free_idx = i;
				end
				if (st == ST_OK && free_idx < 0)
					st = ST_FULL;
				if (st == ST_OK) begin
					slot_live[free_idx]   = 1'b1;
					slot_tag[free_idx]    = r.task_id;
					slot_due[free_idx]    = r.now_us + 64'(r.wait_ms) * 64'(US_PER_MS);
					slot_period[free_idx] = r.repeating ? r.wait_ms : 32'd0;
				end
				batch.push_back(make_result(st, 1'b0, 32'd0));
			end
			KIND_CANCEL: begin
				found = 1'b0;
				for (i = 0; i < SLOTS; i++) begin
					if (slot_live[i] && slot_tag[i] == r.task_id) begin
						slot_live[i]   = 1'b0;
						slot_tag[i]    = '0;
						slot_period[i] = '0;
						found = 1'b1;
					end
				end
				batch.push_back(make_result(found ? ST_OK : ST_NOT_FOUND, 1'b0, 32'd0));
			end
			KIND_TICK: begin
				if (paused) begin
					batch.push_back(make_result(ST_SUSPENDED, 1'b0, 32'd0));
				end else begin
					for (i = 0; i < SLOTS && batch.size() < MAX_RESULTS; i++) begin
						if (slot_live[i] && slot_due[i] <= r.now_us) begin
							batch.push_back(make_result(ST_OK, 1'b1, slot_tag[i]));
							if (slot_period[i] != 0) begin
								slot_due[i] = slot_due[i] + 64'(slot_period[i]) * 64'(US_PER_MS);
							end else begin
								slot_live[i] = 1'b0;
								slot_tag[i]  = '0;
							end
						end
					end
					if (batch.size() == 0)
						batch.push_back(make_result(ST_OK, 1'b0, 32'd0));
				end
			end
			KIND_SUSPEND: begin
				// a second suspend keeps the first start time
				if (!paused) begin
					pause_start = r.now_us;
					paused = 1'b1;
				end
				batch.push_back(make_result(ST_OK, 1'b0, 32'd0));
			end
			KIND_RESUME: begin
				if (paused) begin
					elapsed  = r.now_us - pause_start;
					floor_us = r.now_us + 64'(RESUME_GUARD_US);
					for (i = 0; i < SLOTS; i++) begin
						if (slot_live[i]) begin
							moved = slot_due[i] + elapsed;
							slot_due[i] = (moved > floor_us) ? moved : floor_us;
						end
					end
					paused = 1'b0;
				end
				batch.push_back(make_result(ST_OK, 1'b0, 32'd0));
			end
			default: begin
				batch.push_back(make_result(ST_OK, 1'b0, 32'd0));
			end
		endcase
		any  = 1'b0;
		best = '0;
		for (i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && (!any || slot_due[i] < best)) begin
				best = slot_due[i];
				any  = 1'b1;
			end
		end
		for (i = 0; i < batch.size(); i++) begin
			one = batch[i];
			one.alarm_valid = any;
			one.alarm_time  = any ? best[31:0] : 32'd0;
			one.last        = (i == batch.size() - 1);
			scheduler_results.push_back(one);
		end
	endtask

	task automatic note_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i]   = 1'b0;
				slot_tag[i]    = '0;
				slot_due[i]    = '0;
				slot_period[i] = '0;
			end
			paused       = 1'b0;
			pause_start  = '0;
			fail_count   = 0;
			results_seen = 0;
			fires_seen   = 0;
			scheduler_results.delete();
			pending <= 0;
		end else begin
			// results are checked before the request of the same edge is predicted
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (scheduler_results.size() == 0) begin
					$display("%0t: result transfer %0h with nothing expected", $time, rsp);
					fail_count++;
				end else begin
					want = scheduler_results.pop_front();
					if (want.fired_valid)
						fires_seen++;
					note_field("status", 32'(want.status), 32'(rsp.status));
					note_field("fired_valid", 32'(want.fired_valid), 32'(rsp.fired_valid));
					note_field("fired_id", want.fired_id, rsp.fired_id);
					note_field("alarm_valid", 32'(want.alarm_valid), 32'(rsp.alarm_valid));
					note_field("alarm_time", want.alarm_time, rsp.alarm_time);
					note_field("last", 32'(want.last), 32'(rsp.last));
				end
			end
			if (req_valid && req_ready)
				predict_scheduler(req);
			pending <= scheduler_results.size();
		end
	end

endmodule

[dv/tb_delayed_event_scheduler.sv]
// testbench top for the delayed event scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_delayed_event_scheduler;
	import des_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int fail_count;
	int pending;
	int results_seen;
	int fires_seen;
	int cycles = 0;
	int items_sent = 0;
	logic req_quiet = 1'b0;
	logic rsp_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	delayed_event_scheduler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	des_event_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.fires_seen  (fires_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("delayed_event_scheduler test failed");
			$finish;
		end
	end

	// result side: random stall before each result, with quiet stretches
	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rsp_quiet = ~rsp_quiet;
			stall = rsp_quiet ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	task automatic send_request(input logic [2:0] kind, input logic [31:0] id,
			input logic [31:0] delay, input logic rep, input logic [63:0] now);
		int   gap;
		req_t item;
		item.kind      = kind;
		item.task_id   = id;
		item.wait_ms   = delay;
		item.repeating = rep;
		item.now_us    = now;
		gap = req_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// hold off new requests until every predicted result has been transferred
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [63:0] now_t;
		logic [31:0] id;
		logic [31:0] delay;
		int          pick;
		logic [2:0]  kind;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		now_t     = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_TICK, 32'd0, 32'd0, 1'b0, 64'd0);
		// fill every slot with an event due at once; repeat with zero delay is one-shot
		for (int i = 0; i < 16; i++)
			send_request(KIND_SCHEDULE, 32'(i + 1), 32'd0, 1'(i % 2), 64'd0);
		send_request(KIND_SCHEDULE, 32'd100, 32'd5, 1'b0, 64'd0);
		send_request(KIND_SCHEDULE, 32'd5, 32'd5, 1'b0, 64'd0);
		send_request(KIND_TICK, 32'd0, 32'd0, 1'b0, 64'd0);
		send_request(KIND_CANCEL, 32'd3, 32'd0, 1'b0, 64'd0);
		// target wraps past the top of the time range
		send_request(KIND_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(KIND_SCHEDULE, 32'd7, 32'd2, 1'b1, 64'd1000);
		send_request(KIND_SUSPEND, 32'd0, 32'd0, 1'b0, 64'd1500);
		send_request(KIND_SUSPEND, 32'd0, 32'd0, 1'b0, 64'd2500);
		send_request(KIND_TICK, 32'd0, 32'd0, 1'b0, 64'd9000);
		send_request(KIND_SCHEDULE, 32'd8, 32'd1, 1'b0, 64'd2600);
		send_request(KIND_RESUME, 32'd0, 32'd0, 1'b0, 64'd4000);
		send_request(KIND_RESUME, 32'd0, 32'd0, 1'b0, 64'd4100);
		send_request(KIND_TICK, 32'd0, 32'd0, 1'b0, 64'd10000);
		send_request(KIND_CANCEL, 32'hFFFF_FFFF, 32'd0, 1'b0, 64'd10000);
		send_request(3'd5, $urandom, $urandom, 1'b1, {$urandom, $urandom});
		send_request(3'd7, $urandom, $urandom, 1'b0, {$urandom, $urandom});
		wait_for_results();

		now_t = 64'd20000;
		for (int n = 0; n < 100; n++) begin
			if (n % 20 == 0)
				req_quiet = ($urandom_range(0, 2) == 0);
			if (n == 50)
				wait_for_results();
			now_t = now_t + 64'($urandom_range(0, 3000));
			if ($urandom_range(0, 39) == 0)
				now_t = {$urandom, $urandom};
			id    = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 19));
			delay = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
			pick  = $urandom_range(0, 99);
			if (pick < 36)
				kind = KIND_SCHEDULE;
			else if (pick < 70)
				kind = KIND_TICK;
			else if (pick < 82)
				kind = KIND_CANCEL;
			else if (pick < 89)
				kind = KIND_SUSPEND;
			else if (pick < 97)
				kind = KIND_RESUME;
			else
				kind = 3'($urandom_range(5, 7));
			send_request(kind, id, delay, 1'($urandom_range(0, 1)), now_t);
		end

		wait_for_results();
		repeat (80) @(posedge clk);

		$display("covered %0d requests: schedule, cancel, tick, suspend and resume", items_sent);
		$display("checked %0d results, %0d of them fired events", results_seen, fires_seen);
		if (fail_count == 0 && pending == 0)
			$display("delayed_event_scheduler test passed");
		else
			$display("delayed_event_scheduler test failed");
		$finish;
	end

endmodule
